// ===== hw/rtl/rsrd_pkg.sv =====
// rsrd_pkg: shared types, register codes and the fixed color palette for the
// run-length sprite row decoder. No dependencies.
`default_nettype none

package rsrd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int ADDR_W          = 5;
  localparam int COL_W           = 17;
  localparam logic [31:0] BOUND_INIT = 32'd2147483647;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_COMPRESSED  = 3'd0;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_DRAW_ENABLE = 3'd4;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_LENGTH,
    PH_LITERAL,
    PH_RUN,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        compressed_mode;
    logic [15:0] frame_width;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic        draw_enable;
  } cfg_t;

  typedef struct packed {
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [31:0]          sx;
    logic [31:0]          sy;
    logic [7:0]           count;
    logic [PAL_IDX_W-1:0] pal_idx;
  } span_req_t;

  typedef struct packed {
    logic [31:0] span_x;
    logic [31:0] span_y;
    logic [7:0]  span_length;
    rgb_t        color;
    logic        visible;
    logic [31:0] min_x;
    logic [31:0] max_x;
    logic [31:0] min_y;
    logic [31:0] max_y;
  } span_res_t;

  localparam rgb_t PALETTE [PALETTE_ENTRIES] = '{
    '{6'h00,6'h00,6'h00}, '{6'h3f,6'h3f,6'h2f}, '{6'h3e,6'h3c,6'h08}, '{6'h3f,6'h32,6'h07},
    '{6'h3f,6'h29,6'h05}, '{6'h3f,6'h1f,6'h03}, '{6'h3f,6'h16,6'h02}, '{6'h3f,6'h0c,6'h00},
    '{6'h00,6'h00,6'h00}, '{6'h3f,6'h3f,6'h11}, '{6'h3f,6'h15,6'h14}, '{6'h13,6'h29,6'h14},
    '{6'h00,6'h1d,6'h2f}, '{6'h3f,6'h3f,6'h33}, '{6'h3f,6'h3f,6'h32}, '{6'h3f,6'h3f,6'h35},
    '{6'h3f,6'h3f,6'h3f}, '{6'h3a,6'h3a,6'h3a}, '{6'h35,6'h35,6'h35}, '{6'h30,6'h30,6'h30},
    '{6'h2b,6'h2b,6'h2b}, '{6'h26,6'h26,6'h26}, '{6'h22,6'h22,6'h22}, '{6'h1d,6'h1d,6'h1d},
    '{6'h19,6'h19,6'h19}, '{6'h16,6'h16,6'h16}, '{6'h12,6'h12,6'h12}, '{6'h0e,6'h0e,6'h0e},
    '{6'h0b,6'h0b,6'h0b}, '{6'h07,6'h07,6'h07}, '{6'h03,6'h03,6'h03}, '{6'h00,6'h00,6'h00},
    '{6'h35,6'h1b,6'h11}, '{6'h2e,6'h19,6'h11}, '{6'h27,6'h17,6'h11}, '{6'h21,6'h15,6'h12},
    '{6'h1a,6'h13,6'h12}, '{6'h13,6'h10,6'h13}, '{6'h0d,6'h0e,6'h13}, '{6'h06,6'h0c,6'h13},
    '{6'h36,6'h2d,6'h13}, '{6'h31,6'h29,6'h13}, '{6'h2d,6'h24,6'h14}, '{6'h28,6'h20,6'h15},
    '{6'h23,6'h1c,6'h15}, '{6'h1f,6'h18,6'h16}, '{6'h1a,6'h14,6'h17}, '{6'h15,6'h0f,6'h17},
    '{6'h36,6'h36,6'h3a}, '{6'h31,6'h32,6'h37}, '{6'h2d,6'h2f,6'h33}, '{6'h29,6'h2b,6'h30},
    '{6'h24,6'h27,6'h2d}, '{6'h20,6'h23,6'h29}, '{6'h1b,6'h20,6'h26}, '{6'h17,6'h1c,6'h23},
    '{6'h13,6'h18,6'h1f}, '{6'h10,6'h15,6'h1b}, '{6'h0d,6'h11,6'h16}, '{6'h0b,6'h0e,6'h12},
    '{6'h08,6'h0b,6'h0e}, '{6'h05,6'h07,6'h09}, '{6'h03,6'h04,6'h05}, '{6'h3e,6'h3c,6'h08},
    '{6'h00,6'h18,6'h37}, '{6'h00,6'h0c,6'h1c}, '{6'h3e,6'h38,6'h08}, '{6'h22,6'h08,6'h02},
    '{6'h00,6'h2d,6'h03}, '{6'h00,6'h1b,6'h02}, '{6'h3f,6'h35,6'h07}, '{6'h3f,6'h31,6'h06},
    '{6'h2d,6'h2c,6'h22}, '{6'h28,6'h27,6'h1d}, '{6'h23,6'h22,6'h18}, '{6'h1d,6'h1d,6'h12},
    '{6'h17,6'h17,6'h0f}, '{6'h11,6'h11,6'h0b}, '{6'h0a,6'h0a,6'h07}, '{6'h05,6'h05,6'h03},
    '{6'h36,6'h36,6'h36}, '{6'h35,6'h32,6'h32}, '{6'h32,6'h2e,6'h2e}, '{6'h2e,6'h2a,6'h2a},
    '{6'h2a,6'h26,6'h26}, '{6'h27,6'h22,6'h22}, '{6'h23,6'h1e,6'h1e}, '{6'h1f,6'h1a,6'h1a},
    '{6'h1d,6'h17,6'h17}, '{6'h1c,6'h14,6'h14}, '{6'h1a,6'h11,6'h11}, '{6'h18,6'h0e,6'h0e},
    '{6'h13,6'h0a,6'h0a}, '{6'h0e,6'h07,6'h07}, '{6'h09,6'h04,6'h04}, '{6'h3f,6'h2d,6'h06},
    '{6'h3f,6'h3f,6'h3a}, '{6'h3f,6'h3b,6'h32}, '{6'h3f,6'h2a,6'h05}, '{6'h3f,6'h26,6'h04},
    '{6'h3f,6'h2f,6'h19}, '{6'h3f,6'h2b,6'h11}, '{6'h3f,6'h27,6'h08}, '{6'h3f,6'h22,6'h04},
    '{6'h38,6'h1e,6'h00}, '{6'h32,6'h19,6'h00}, '{6'h2b,6'h15,6'h00}, '{6'h24,6'h10,6'h00},
    '{6'h1e,6'h0b,6'h00}, '{6'h17,6'h06,6'h00}, '{6'h10,6'h01,6'h00}, '{6'h0a,6'h00,6'h00},
    '{6'h36,6'h2f,6'h2c}, '{6'h33,6'h2b,6'h28}, '{6'h31,6'h27,6'h24}, '{6'h2e,6'h23,6'h20},
    '{6'h2b,6'h1f,6'h1c}, '{6'h29,6'h1c,6'h19}, '{6'h24,6'h19,6'h17}, '{6'h1f,6'h16,6'h16},
    '{6'h1b,6'h14,6'h15}, '{6'h16,6'h11,6'h13}, '{6'h11,6'h0f,6'h12}, '{6'h0d,6'h0c,6'h11},
    '{6'h0a,6'h0a,6'h0d}, '{6'h07,6'h07,6'h0a}, '{6'h04,6'h04,6'h06}, '{6'h01,6'h02,6'h03},
    '{6'h35,6'h3b,6'h36}, '{6'h2e,6'h36,6'h31}, '{6'h26,6'h30,6'h2c}, '{6'h1f,6'h2a,6'h27},
    '{6'h17,6'h24,6'h22}, '{6'h10,6'h1b,6'h1a}, '{6'h08,6'h11,6'h12}, '{6'h01,6'h07,6'h09},
    '{6'h3f,6'h32,6'h2b}, '{6'h3a,6'h2b,6'h25}, '{6'h35,6'h24,6'h20}, '{6'h2f,6'h1d,6'h1a},
    '{6'h2a,6'h16,6'h15}, '{6'h24,6'h10,6'h10}, '{6'h1c,6'h0a,6'h0c}, '{6'h16,6'h04,6'h07},
    '{6'h37,6'h34,6'h2a}, '{6'h32,6'h31,6'h28}, '{6'h2d,6'h2e,6'h25}, '{6'h28,6'h2b,6'h23},
    '{6'h22,6'h28,6'h21}, '{6'h1d,6'h25,6'h1f}, '{6'h18,6'h22,6'h1d}, '{6'h13,6'h1f,6'h1a},
    '{6'h11,6'h1b,6'h18}, '{6'h0f,6'h18,6'h15}, '{6'h0c,6'h14,6'h13}, '{6'h0a,6'h11,6'h10},
    '{6'h07,6'h0d,6'h0d}, '{6'h05,6'h0a,6'h0b}, '{6'h03,6'h06,6'h08}, '{6'h00,6'h03,6'h05},
    '{6'h3f,6'h1e,6'h03}, '{6'h3f,6'h37,6'h2a}, '{6'h3f,6'h34,6'h25}, '{6'h3f,6'h32,6'h20},
    '{6'h36,6'h2c,6'h20}, '{6'h2c,6'h27,6'h1f}, '{6'h23,6'h21,6'h1e}, '{6'h19,6'h1c,6'h1e},
    '{6'h10,6'h16,6'h1d}, '{6'h06,6'h11,6'h1d}, '{6'h05,6'h0f,6'h19}, '{6'h04,6'h0c,6'h15},
    '{6'h03,6'h0a,6'h11}, '{6'h02,6'h07,6'h0d}, '{6'h01,6'h05,6'h09}, '{6'h3f,6'h1b,6'h03},
    '{6'h3d,6'h37,6'h33}, '{6'h3a,6'h35,6'h2f}, '{6'h37,6'h32,6'h2a}, '{6'h33,6'h2f,6'h25},
    '{6'h30,6'h2c,6'h20}, '{6'h2c,6'h29,6'h1b}, '{6'h29,6'h25,6'h18}, '{6'h26,6'h22,6'h16},
    '{6'h23,6'h1e,6'h13}, '{6'h1f,6'h1a,6'h10}, '{6'h1a,6'h16,6'h0e}, '{6'h16,6'h12,6'h0b},
    '{6'h12,6'h0e,6'h08}, '{6'h0d,6'h0a,6'h05}, '{6'h09,6'h06,6'h02}, '{6'h04,6'h01,6'h00},
    '{6'h3f,6'h39,6'h2e}, '{6'h3c,6'h33,6'h29}, '{6'h38,6'h2d,6'h24}, '{6'h34,6'h26,6'h1e},
    '{6'h30,6'h20,6'h19}, '{6'h2c,6'h19,6'h14}, '{6'h28,6'h13,6'h0e}, '{6'h24,6'h0d,6'h09},
    '{6'h21,6'h06,6'h03}, '{6'h1d,6'h05,6'h03}, '{6'h19,6'h04,6'h02}, '{6'h15,6'h04,6'h02},
    '{6'h11,6'h03,6'h02}, '{6'h0d,6'h02,6'h01}, '{6'h09,6'h01,6'h01}, '{6'h06,6'h01,6'h01},
    '{6'h3f,6'h36,6'h2c}, '{6'h3c,6'h31,6'h28}, '{6'h39,6'h2d,6'h23}, '{6'h36,6'h29,6'h1f},
    '{6'h33,6'h24,6'h1b}, '{6'h2f,6'h20,6'h16}, '{6'h2c,6'h1b,6'h12}, '{6'h2a,6'h18,6'h11},
    '{6'h28,6'h16,6'h10}, '{6'h26,6'h13,6'h0f}, '{6'h24,6'h10,6'h0d}, '{6'h22,6'h0d,6'h0c},
    '{6'h1a,6'h0a,6'h0a}, '{6'h11,6'h08,6'h08}, '{6'h08,6'h05,6'h06}, '{6'h3f,6'h17,6'h02},
    '{6'h3f,6'h33,6'h2f}, '{6'h3f,6'h30,6'h2c}, '{6'h3f,6'h2d,6'h29}, '{6'h3e,6'h2a,6'h26},
    '{6'h3e,6'h27,6'h23}, '{6'h3d,6'h24,6'h20}, '{6'h3d,6'h20,6'h1e}, '{6'h3d,6'h1d,6'h1b},
    '{6'h3c,6'h1a,6'h18}, '{6'h3c,6'h17,6'h15}, '{6'h3b,6'h14,6'h12}, '{6'h3b,6'h11,6'h0f},
    '{6'h3b,6'h0e,6'h0c}, '{6'h3a,6'h0b,6'h0a}, '{6'h3a,6'h07,6'h07}, '{6'h39,6'h04,6'h04},
    '{6'h39,6'h02,6'h02}, '{6'h35,6'h02,6'h02}, '{6'h31,6'h01,6'h01}, '{6'h2e,6'h01,6'h01},
    '{6'h2a,6'h01,6'h01}, '{6'h26,6'h01,6'h01}, '{6'h22,6'h01,6'h01}, '{6'h1e,6'h01,6'h01},
    '{6'h1b,6'h01,6'h01}, '{6'h17,6'h01,6'h01}, '{6'h13,6'h01,6'h01}, '{6'h3f,6'h13,6'h01},
    '{6'h3f,6'h10,6'h01}, '{6'h08,6'h00,6'h00}, '{6'h3f,6'h0c,6'h00}, '{6'h0c,6'h2e,6'h2b}
  };

endpackage

`default_nettype wire

// ===== hw/rtl/rle_sprite_row_decoder.sv =====
// rle_sprite_row_decoder: run-length sprite row decoder, top level.
// A span goes through the span request register, then the result register.
// Throughput: one input byte per cycle while in_stall is low; the parse step
// and the bounding box update never wait; stalls only come from the output side.
// Reset (synchronous): parse state to skip phase, box to empty, registers to 0.
// Uses rsrd_pkg, rsrd_parser and rsrd_bounds.
`default_nettype none

module rle_sprite_row_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rsrd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        row_start,
  input  wire logic [15:0]                 row_index,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [31:0]                      span_x,
  output logic [31:0]                      span_y,
  output logic [7:0]                       span_length,
  output logic [5:0]                       color_red,
  output logic [5:0]                       color_green,
  output logic [5:0]                       color_blue,
  output logic                             visible,
  output logic [31:0]                      bound_min_x,
  output logic [31:0]                      bound_max_x,
  output logic [31:0]                      bound_min_y,
  output logic [31:0]                      bound_max_y
);

  rsrd_pkg::cfg_t      cfg;
  rsrd_pkg::span_req_t req, span_req;
  rsrd_pkg::span_res_t res;
  logic                emit, span_valid;
  logic                accept, out_free, span_move, cfg_write;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        rsrd_pkg::REG_COMPRESSED:  cfg.compressed_mode <= pwdata[0];
        rsrd_pkg::REG_FRAME_WIDTH: cfg.frame_width     <= pwdata[15:0];
        rsrd_pkg::REG_ORIGIN_X:    cfg.origin_x        <= pwdata;
        rsrd_pkg::REG_ORIGIN_Y:    cfg.origin_y        <= pwdata;
        rsrd_pkg::REG_DRAW_ENABLE: cfg.draw_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rsrd_pkg::REG_COMPRESSED:  prdata = {31'b0, cfg.compressed_mode};
      rsrd_pkg::REG_FRAME_WIDTH: prdata = {16'b0, cfg.frame_width};
      rsrd_pkg::REG_ORIGIN_X:    prdata = cfg.origin_x;
      rsrd_pkg::REG_ORIGIN_Y:    prdata = cfg.origin_y;
      rsrd_pkg::REG_DRAW_ENABLE: prdata = {31'b0, cfg.draw_enable};
      default:                   prdata = '0;
    endcase
  end

  // pipeline flow: span stage drains into the output register when it is free
  assign out_free  = !out_valid || !out_stall;
  assign span_move = span_valid && out_free;
  assign in_stall  = span_valid && !out_free;
  assign accept    = in_valid && !in_stall;

  rsrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .row_start (row_start),
    .row_index (row_index),
    .cfg       (cfg),
    .emit      (emit),
    .req       (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (accept) begin
      span_valid <= emit;
    end else if (span_move) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      span_req <= req;
    end
  end

  rsrd_bounds u_bounds (
    .clk         (clk),
    .rst         (rst),
    .load        (span_move),
    .draw_enable (cfg.draw_enable),
    .req         (span_req),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (span_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign span_x      = res.span_x;
  assign span_y      = res.span_y;
  assign span_length = res.span_length;
  assign color_red   = res.color.red;
  assign color_green = res.color.green;
  assign color_blue  = res.color.blue;
  assign visible     = res.visible;
  assign bound_min_x = res.min_x;
  assign bound_max_x = res.max_x;
  assign bound_min_y = res.min_y;
  assign bound_max_y = res.max_y;

endmodule

`default_nettype wire

// ===== hw/rtl/rsrd_parser.sv =====
// rsrd_parser: row byte parser; tracks group phase, column and count and
// builds a span request per emitted span. Depends on rsrd_pkg.
`default_nettype none

module rsrd_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               row_start,
  input  wire logic [15:0]        row_index,
  input  wire rsrd_pkg::cfg_t     cfg,
  output logic                    emit,
  output rsrd_pkg::span_req_t     req
);

  rsrd_pkg::phase_t               phase, phase_next;
  logic [rsrd_pkg::COL_W-1:0]     column, column_next;
  logic [7:0]                     remaining, remaining_next;

  rsrd_pkg::phase_t               ph0;
  logic [rsrd_pkg::COL_W-1:0]     col0;
  logic [7:0]                     rem0;
  logic [rsrd_pkg::COL_W-1:0]     col_skip, col_lit, col_run, fw_ext;
  logic [7:0]                     len_count, rem_dec;

  always_comb begin
    // row start restarts the row before the byte itself is parsed
    col0   = row_start ? '0 : column;
    rem0   = row_start ? '0 : remaining;
    ph0    = phase;
    if (row_start) begin
      ph0 = (cfg.frame_width == '0) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
    end
    fw_ext    = {1'b0, cfg.frame_width};
    col_skip  = col0 + {{(rsrd_pkg::COL_W-8){1'b0}}, data_byte};
    col_lit   = col0 + {{(rsrd_pkg::COL_W-1){1'b0}}, 1'b1};
    col_run   = col0 + {{(rsrd_pkg::COL_W-8){1'b0}}, rem0};
    len_count = cfg.compressed_mode ? {1'b0, data_byte[7:1]} : data_byte;
    rem_dec   = rem0 - 8'd1;

    phase_next     = ph0;
    column_next    = col0;
    remaining_next = rem0;
    emit           = 1'b0;
    req.count      = 8'd1;

    case (ph0)
      rsrd_pkg::PH_SKIP: begin
        column_next = col_skip;
        phase_next  = (col_skip >= fw_ext) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_LENGTH;
      end
      rsrd_pkg::PH_LENGTH: begin
        remaining_next = len_count;
        if (cfg.compressed_mode && data_byte[0]) begin
          phase_next = rsrd_pkg::PH_RUN;
        end else if (len_count == '0) begin
          phase_next = (col0 >= fw_ext) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
        end else begin
          phase_next = rsrd_pkg::PH_LITERAL;
        end
      end
      rsrd_pkg::PH_LITERAL: begin
        emit           = 1'b1;
        column_next    = col_lit;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = (col_lit >= fw_ext) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
        end
      end
      rsrd_pkg::PH_RUN: begin
        // a zero-count run swallows its palette byte silently
        if (rem0 != '0) begin
          emit        = 1'b1;
          req.count   = rem0;
          column_next = col_run;
        end
        remaining_next = '0;
        phase_next = (column_next >= fw_ext) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
      end
      default: begin
        phase_next = rsrd_pkg::PH_DONE;
      end
    endcase

    req.sx      = cfg.origin_x + {{(32-rsrd_pkg::COL_W){1'b0}}, col0};
    req.sy      = cfg.origin_y + {16'b0, row_index};
    req.pal_idx = data_byte[rsrd_pkg::PAL_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rsrd_pkg::PH_SKIP;
      column    <= '0;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      column    <= column_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsrd_bounds.sv =====
// rsrd_bounds: palette lookup, visibility and running bounding box; registers
// the finished span result. Depends on rsrd_pkg.
`default_nettype none

module rsrd_bounds (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 draw_enable,
  input  wire rsrd_pkg::span_req_t  req,
  output rsrd_pkg::span_res_t       res
);

  logic [31:0]    min_x, max_x, min_y, max_y;
  logic [31:0]    min_x_next, max_x_next, min_y_next, max_y_next;
  logic [31:0]    end_x, lo_x, hi_x;
  logic           wrap, vis;
  rsrd_pkg::rgb_t color;

  always_comb begin
    color = rsrd_pkg::PALETTE[req.pal_idx];
    end_x = req.sx + {24'b0, req.count - 8'd1};
    // span running past the top of x covers both ends of the range
    wrap  = end_x < req.sx;
    lo_x  = wrap ? '0 : req.sx;
    hi_x  = wrap ? '1 : end_x;
    vis   = !(draw_enable && (color == '0));

    min_x_next = min_x;
    max_x_next = max_x;
    min_y_next = min_y;
    max_y_next = max_y;
    if (vis) begin
      if (lo_x < min_x)   min_x_next = lo_x;
      if (hi_x > max_x)   max_x_next = hi_x;
      if (req.sy < min_y) min_y_next = req.sy;
      if (req.sy > max_y) max_y_next = req.sy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= rsrd_pkg::BOUND_INIT;
      max_x <= '0;
      min_y <= rsrd_pkg::BOUND_INIT;
      max_y <= '0;
    end else if (load) begin
      min_x <= min_x_next;
      max_x <= max_x_next;
      min_y <= min_y_next;
      max_y <= max_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.span_x      <= req.sx;
      res.span_y      <= req.sy;
      res.span_length <= req.count;
      res.color       <= color;
      res.visible     <= vis;
      res.min_x       <= min_x_next;
      res.max_x       <= max_x_next;
      res.min_y       <= min_y_next;
      res.max_y       <= max_y_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsrd_checker.sv =====
// rsrd_checker: port-level checks for the sprite row decoder, attached to the
// top level by the bind below. Sees only the top level's ports.
`default_nettype none

module rsrd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] span_x,
  input wire logic [31:0] span_y,
  input wire logic [7:0]  span_length,
  input wire logic        visible,
  input wire logic [31:0] bound_min_x,
  input wire logic [31:0] bound_max_x,
  input wire logic [31:0] bound_min_y,
  input wire logic [31:0] bound_max_y
);

  // a visible span's start always lies inside the box it reports
  a_box_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> bound_min_x <= span_x && bound_max_x >= span_x)
    else $error("visible span x outside reported box");

  a_box_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> bound_min_y <= span_y && bound_max_y >= span_y)
    else $error("visible span y outside reported box");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> span_length != 8'd0)
    else $error("span of zero length");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span_x) && $stable(bound_max_x))
    else $error("stalled transfer changed");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rle_sprite_row_decoder rsrd_checker u_rsrd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .span_x      (span_x),
  .span_y      (span_y),
  .span_length (span_length),
  .visible     (visible),
  .bound_min_x (bound_min_x),
  .bound_max_x (bound_max_x),
  .bound_min_y (bound_min_y),
  .bound_max_y (bound_max_y)
);

`default_nettype wire

// ===== verif/rsrd_span_checker.sv =====
// rsrd_span_checker: follows the register port and both channels of the sprite row decoder,
// predicts the span of each input transfer and compares it with the output transfers.
// Depends on rsrd_pkg for the register codes, parse phases, span record and palette.
module rsrd_span_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rsrd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  input  wire logic                        pready,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        row_start,
  input  wire logic [15:0]                 row_index,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [31:0]                 span_x,
  input  wire logic [31:0]                 span_y,
  input  wire logic [7:0]                  span_length,
  input  wire logic [5:0]                  color_red,
  input  wire logic [5:0]                  color_green,
  input  wire logic [5:0]                  color_blue,
  input  wire logic                        visible,
  input  wire logic [31:0]                 bound_min_x,
  input  wire logic [31:0]                 bound_max_x,
  input  wire logic [31:0]                 bound_min_y,
  input  wire logic [31:0]                 bound_max_y,
  output int                               mismatch_count,
  output int                               spans_pending
);

  rsrd_pkg::cfg_t             cfg;
  rsrd_pkg::phase_t           phase;
  logic [rsrd_pkg::COL_W-1:0] column;
  logic [7:0]                 remaining;
  logic [31:0]                min_x, max_x, min_y, max_y;
  rsrd_pkg::span_res_t        expected_spans[$];

  function automatic void end_group();
    phase = (column >= {1'b0, cfg.frame_width}) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
  endfunction

  task automatic predict_span(input logic [7:0] idx, input logic [7:0] count,
                              input logic [15:0] row);
    rsrd_pkg::span_res_t s;
    logic [31:0]         last_x, lo_x, hi_x;
    s.span_x      = cfg.origin_x + {15'd0, column};
    s.span_y      = cfg.origin_y + {16'd0, row};
    s.span_length = count;
    s.color       = rsrd_pkg::PALETTE[idx];
    s.visible     = !(cfg.draw_enable && s.color == '0);
    last_x = s.span_x + {24'd0, count} - 32'd1;
    lo_x   = s.span_x;
    hi_x   = last_x;
    // a run that wraps past the top of x covers both ends of the axis
    if (last_x < s.span_x) begin
      lo_x = '0;
      hi_x = '1;
    end
    if (s.visible) begin
      if (lo_x < min_x) min_x = lo_x;
      if (hi_x > max_x) max_x = hi_x;
      if (s.span_y < min_y) min_y = s.span_y;
      if (s.span_y > max_y) max_y = s.span_y;
    end
    s.min_x = min_x;
    s.max_x = max_x;
    s.min_y = min_y;
    s.max_y = max_y;
    expected_spans = {expected_spans, s};
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic rs, input logic [15:0] row);
    if (rs) begin
      column    = '0;
      remaining = '0;
      phase     = (cfg.frame_width == 16'd0) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_SKIP;
    end
    case (phase)
      rsrd_pkg::PH_SKIP: begin
        column = column + {9'd0, b};
        phase  = (column >= {1'b0, cfg.frame_width}) ? rsrd_pkg::PH_DONE
                                                     : rsrd_pkg::PH_LENGTH;
      end
      rsrd_pkg::PH_LENGTH: begin
        if (cfg.compressed_mode && b[0]) begin
          remaining = {1'b0, b[7:1]};
          phase     = rsrd_pkg::PH_RUN;
        end else begin
          remaining = cfg.compressed_mode ? {1'b0, b[7:1]} : b;
          if (remaining == 8'd0) end_group();
          else phase = rsrd_pkg::PH_LITERAL;
        end
      end
      rsrd_pkg::PH_LITERAL: begin
        predict_span(b, 8'd1, row);
        column    = column + 17'd1;
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) end_group();
      end
      rsrd_pkg::PH_RUN: begin
        // a zero-length run still takes its color byte
        if (remaining != 8'd0) begin
          predict_span(b, remaining, row);
          column = column + {9'd0, remaining};
        end
        remaining = '0;
        end_group();
      end
      default: phase = rsrd_pkg::PH_DONE;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_span();
    rsrd_pkg::span_res_t want;
    if (expected_spans.size() == 0) begin
      $display("%0t: span with none expected, x %h y %h length %0d",
               $time, span_x, span_y, span_length);
      mismatch_count++;
    end else begin
      want = expected_spans.pop_front();
      check_field("span_x", want.span_x, span_x);
      check_field("span_y", want.span_y, span_y);
      check_field("span_length", {24'd0, want.span_length}, {24'd0, span_length});
      check_field("color_red", {26'd0, want.color.red}, {26'd0, color_red});
      check_field("color_green", {26'd0, want.color.green}, {26'd0, color_green});
      check_field("color_blue", {26'd0, want.color.blue}, {26'd0, color_blue});
      check_field("visible", {31'd0, want.visible}, {31'd0, visible});
      check_field("bound_min_x", want.min_x, bound_min_x);
      check_field("bound_max_x", want.max_x, bound_max_x);
      check_field("bound_min_y", want.min_y, bound_min_y);
      check_field("bound_max_y", want.max_y, bound_max_y);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg       = '0;
      phase     = rsrd_pkg::PH_SKIP;
      column    = '0;
      remaining = '0;
      min_x     = rsrd_pkg::BOUND_INIT;
      max_x     = '0;
      min_y     = rsrd_pkg::BOUND_INIT;
      max_y     = '0;
      expected_spans.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[rsrd_pkg::ADDR_W-1:2])
          rsrd_pkg::REG_COMPRESSED:  cfg.compressed_mode = pwdata[0];
          rsrd_pkg::REG_FRAME_WIDTH: cfg.frame_width     = pwdata[15:0];
          rsrd_pkg::REG_ORIGIN_X:    cfg.origin_x        = pwdata;
          rsrd_pkg::REG_ORIGIN_Y:    cfg.origin_y        = pwdata;
          rsrd_pkg::REG_DRAW_ENABLE: cfg.draw_enable     = pwdata[0];
          default: ;
        endcase
      end
      // input first, so a span leaving in the same cycle finds its expectation
      if (in_valid && !in_stall) decode_byte(data_byte, row_start, row_index);
      if (out_valid && !out_stall) check_span();
    end
    spans_pending <= expected_spans.size();
  end

endmodule

// ===== verif/rle_sprite_row_decoder_tb.sv =====
// rle_sprite_row_decoder_tb: drives encoded sprite rows and register settings into the
// decoder with random gaps and output stalls; rsrd_span_checker judges every span.
// Depends on rsrd_pkg, rle_sprite_row_decoder and rsrd_span_checker.
module rle_sprite_row_decoder_tb;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rsrd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  data_byte = '0;
  logic                        row_start = 1'b0;
  logic [15:0]                 row_index = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [31:0]                 span_x, span_y;
  logic [7:0]                  span_length;
  logic [5:0]                  color_red, color_green, color_blue;
  logic                        visible;
  logic [31:0]                 bound_min_x, bound_max_x, bound_min_y, bound_max_y;
  int                          mismatch_count;
  int                          spans_pending;

  bit steady = 1'b0;
  bit cur_compressed = 1'b0;
  int sent_bytes = 0;
  int idle_cycles = 0;

  rle_sprite_row_decoder i_dut (.*);
  rsrd_span_checker u_span_check (.*);

  always #5 clk = ~clk;

  // ends the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output side: a random stall, none in steady mode, before every span transfer
  initial begin : span_stall_gen
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input bit cm, input logic [15:0] fw, input logic [31:0] ox,
                            input logic [31:0] oy, input bit de);
    reg_write(rsrd_pkg::REG_COMPRESSED, {31'd0, cm});
    reg_write(rsrd_pkg::REG_FRAME_WIDTH, {16'd0, fw});
    reg_write(rsrd_pkg::REG_ORIGIN_X, ox);
    reg_write(rsrd_pkg::REG_ORIGIN_Y, oy);
    reg_write(rsrd_pkg::REG_DRAW_ENABLE, {31'd0, de});
    cur_compressed = cm;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic rs, input logic [15:0] row);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    row_start <= rs;
    row_index <= row;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  // waits for every expected span, then for the pipeline to settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (spans_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // black entries show up often enough to exercise hidden spans
  function automatic logic [7:0] palette_pick();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'h08;
      2: return 8'h1F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_row(input bit with_start);
    logic [15:0] row;
    logic [7:0]  skip, count;
    bit          run, first;
    int          groups;
    row    = 16'($urandom_range(0, 65535));
    groups = $urandom_range(1, 4);
    first  = with_start;
    repeat (groups) begin
      skip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 6));
      send_byte(skip, first, row);
      first = 1'b0;
      run   = cur_compressed && ($urandom_range(0, 2) == 0);
      if (cur_compressed) begin
        count = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 127))
                                             : 8'($urandom_range(0, 6));
        send_byte({count[6:0], run}, 1'b0, row);
      end else begin
        count = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(7, 40))
                                             : 8'($urandom_range(0, 6));
        send_byte(count, 1'b0, row);
      end
      if (run) send_byte(palette_pick(), 1'b0, row);
      else repeat (count) send_byte(palette_pick(), 1'b0, row);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                16'($urandom_range(0, 65535)));
  endtask

  task automatic run_phase(input int bytes);
    int stop;
    stop = sent_bytes + bytes;
    // the first row may carry on from whatever state the last phase left
    send_row(1'($urandom_range(0, 1)));
    while (sent_bytes < stop) begin
      case ($urandom_range(0, 29))
        0: drain();
        1, 2, 3: send_noise();
        default: send_row(1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b1, 16'd40, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    // no row start yet: an implicit row at column zero
    send_byte(8'h03, 1'b0, 16'd5);
    send_byte(8'h05, 1'b0, 16'd5);     // run of two
    send_byte(8'h10, 1'b0, 16'd5);
    send_byte(8'h00, 1'b0, 16'd5);
    send_byte(8'h04, 1'b0, 16'd5);     // literal of two
    send_byte(8'h00, 1'b0, 16'd5);     // black, hidden while drawing
    send_byte(8'hFF, 1'b0, 16'd5);
    send_byte(8'h00, 1'b0, 16'd5);
    send_byte(8'h01, 1'b0, 16'd5);     // zero-length run still eats its color byte
    send_byte(8'h33, 1'b0, 16'd5);
    send_byte(8'h00, 1'b0, 16'd5);
    send_byte(8'h00, 1'b0, 16'd5);     // zero-length literal
    send_byte(8'h00, 1'b1, 16'hFFFF);
    send_byte(8'hFF, 1'b0, 16'hFFFF);  // run of 127 wraps past the top of x
    send_byte(8'h01, 1'b0, 16'hFFFF);
    send_byte(8'hAA, 1'b0, 16'hFFFF);  // row already past the frame width
    send_byte(8'd40, 1'b1, 16'd1);     // skip lands right on the frame width
    send_byte(8'h03, 1'b0, 16'd1);
    drain();
    set_config(1'b0, 16'd0, 32'd0, 32'd0, 1'b0);
    send_byte(8'h00, 1'b1, 16'd2);     // zero width drops the whole row
    drain();
    set_config(1'b0, 16'hFFFF, 32'd0, 32'd0, 1'b0);
    send_byte(8'hFF, 1'b1, 16'd0);
    send_byte(8'h03, 1'b0, 16'd0);     // low bit means nothing outside compressed mode
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h80, 1'b0, 16'd0);
    send_byte(8'h7F, 1'b0, 16'd0);

    drain();
    set_config(1'b1, 16'($urandom_range(16, 120)), $urandom, $urandom, 1'b1);
    run_phase(120);
    drain();
    set_config(1'b0, 16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    run_phase(120);
    drain();
    steady = 1'b1;
    set_config(1'b1, 16'($urandom_range(1, 40)), 32'd0, 32'd0, 1'b1);
    run_phase(120);
    drain();
    steady = 1'b0;
    set_config(1'b1, 16'($urandom_range(1, 300)), 32'hFFFF_FF00 + $urandom_range(0, 255),
               $urandom, 1'($urandom_range(0, 1)));
    run_phase(120);

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && spans_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rsrd_pkg.sv
hw/rtl/rsrd_parser.sv
hw/rtl/rsrd_bounds.sv
hw/rtl/rle_sprite_row_decoder.sv
hw/rtl/rsrd_checker.sv
verif/rsrd_span_checker.sv
verif/rle_sprite_row_decoder_tb.sv
